### hw/rtl/qvr_pkg.sv
// Shared widths, register indexes and types for the quaternion vector rotator.
package qvr_pkg;

    localparam int QUAT_W    = 16;
    localparam int QUAT_FRAC = 14;
    localparam int VEC_W     = 24;
    localparam int PROD_W    = 2 * QUAT_W;
    localparam int MAT_W     = PROD_W + 2;
    localparam int TERM_W    = MAT_W + VEC_W;
    localparam int SUM_W     = TERM_W + 2;
    localparam int SHIFT     = 2 * QUAT_FRAC;
    localparam int SH_W      = SUM_W - SHIFT;
    localparam int CFG_IDX_W = 2;
    localparam int SETTLE_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = 2'd3;

    localparam logic signed [QUAT_W-1:0] QUAT_ONE      = 16'sd16384;
    localparam logic [SETTLE_W-1:0]      SETTLE_CYCLES = 2'd2;

    typedef struct packed {
        logic signed [MAT_W-1:0] c0;
        logic signed [MAT_W-1:0] c1;
        logic signed [MAT_W-1:0] c2;
    } mat_row_t;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } lane_ctl_t;

endpackage

### hw/rtl/qvr_matrix.sv
// Quaternion registers and the two-stage rotation matrix build.
module qvr_matrix
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [qvr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [qvr_pkg::QUAT_W-1:0]          cfg_data,
    output qvr_pkg::mat_row_t                   row0,
    output qvr_pkg::mat_row_t                   row1,
    output qvr_pkg::mat_row_t                   row2,
    output logic                                busy
);

    logic signed [qvr_pkg::QUAT_W-1:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic [qvr_pkg::SETTLE_W-1:0]      settle_reg;
    logic [qvr_pkg::SETTLE_W-1:0]      settle_next;

    logic signed [qvr_pkg::PROD_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [qvr_pkg::PROD_W-1:0] wx_reg, wy_reg, wz_reg;
    logic signed [qvr_pkg::PROD_W-1:0] xy_reg, xz_reg, yz_reg;

    qvr_pkg::mat_row_t row0_reg, row1_reg, row2_reg;
    qvr_pkg::mat_row_t row0_next, row1_next, row2_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qw_reg     <= qvr_pkg::QUAT_ONE;
            qx_reg     <= '0;
            qy_reg     <= '0;
            qz_reg     <= '0;
            settle_reg <= qvr_pkg::SETTLE_CYCLES;
        end
        else
        begin
            settle_reg <= settle_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    qvr_pkg::REG_QUAT_W: qw_reg <= $signed(cfg_data);
                    qvr_pkg::REG_QUAT_X: qx_reg <= $signed(cfg_data);
                    qvr_pkg::REG_QUAT_Y: qy_reg <= $signed(cfg_data);
                    qvr_pkg::REG_QUAT_Z: qz_reg <= $signed(cfg_data);
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        if (cfg_wr_en)
            settle_next = qvr_pkg::SETTLE_CYCLES;
        else if (settle_reg != '0)
            settle_next = settle_reg - 1'b1;
        else
            settle_next = settle_reg;
    end

    // stage A: pairwise products
    always_ff @(posedge clk)
    begin
        ww_reg <= qw_reg * qw_reg;
        xx_reg <= qx_reg * qx_reg;
        yy_reg <= qy_reg * qy_reg;
        zz_reg <= qz_reg * qz_reg;
        wx_reg <= qw_reg * qx_reg;
        wy_reg <= qw_reg * qy_reg;
        wz_reg <= qw_reg * qz_reg;
        xy_reg <= qx_reg * qy_reg;
        xz_reg <= qx_reg * qz_reg;
        yz_reg <= qy_reg * qz_reg;
    end

    // stage B: matrix entries
    always_comb
    begin
        logic signed [qvr_pkg::MAT_W-1:0] eww, exx, eyy, ezz;
        logic signed [qvr_pkg::MAT_W-1:0] ewx, ewy, ewz, exy, exz, eyz;
        eww = qvr_pkg::MAT_W'(ww_reg);
        exx = qvr_pkg::MAT_W'(xx_reg);
        eyy = qvr_pkg::MAT_W'(yy_reg);
        ezz = qvr_pkg::MAT_W'(zz_reg);
        ewx = qvr_pkg::MAT_W'(wx_reg);
        ewy = qvr_pkg::MAT_W'(wy_reg);
        ewz = qvr_pkg::MAT_W'(wz_reg);
        exy = qvr_pkg::MAT_W'(xy_reg);
        exz = qvr_pkg::MAT_W'(xz_reg);
        eyz = qvr_pkg::MAT_W'(yz_reg);

        row0_next.c0 = eww + exx - eyy - ezz;
        row0_next.c1 = (exy - ewz) <<< 1;
        row0_next.c2 = (exz + ewy) <<< 1;
        row1_next.c0 = (exy + ewz) <<< 1;
        row1_next.c1 = eww - exx + eyy - ezz;
        row1_next.c2 = (eyz - ewx) <<< 1;
        row2_next.c0 = (exz - ewy) <<< 1;
        row2_next.c1 = (eyz + ewx) <<< 1;
        row2_next.c2 = eww - exx - eyy + ezz;
    end

    always_ff @(posedge clk)
    begin
        row0_reg <= row0_next;
        row1_reg <= row1_next;
        row2_reg <= row2_next;
    end

    assign row0 = row0_reg;
    assign row1 = row1_reg;
    assign row2 = row2_reg;
    assign busy = (settle_reg != '0);

endmodule

### hw/rtl/qvr_lane.sv
// One output component: three products, sum, round and saturate.
module qvr_lane
(
    input  logic                                clk,
    input  qvr_pkg::lane_ctl_t                  ctl,
    input  qvr_pkg::mat_row_t                   row,
    input  logic signed [qvr_pkg::VEC_W-1:0]    vx,
    input  logic signed [qvr_pkg::VEC_W-1:0]    vy,
    input  logic signed [qvr_pkg::VEC_W-1:0]    vz,
    output logic signed [qvr_pkg::VEC_W-1:0]    rot,
    output logic                                ovf
);

    localparam logic signed [qvr_pkg::SUM_W-1:0] RND_HALF =
        qvr_pkg::SUM_W'(1) <<< (qvr_pkg::SHIFT - 1);
    localparam logic signed [qvr_pkg::VEC_W-1:0] SAT_MAX =
        {1'b0, {(qvr_pkg::VEC_W-1){1'b1}}};
    localparam logic signed [qvr_pkg::VEC_W-1:0] SAT_MIN =
        {1'b1, {(qvr_pkg::VEC_W-1){1'b0}}};

    logic signed [qvr_pkg::TERM_W-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [qvr_pkg::SUM_W-1:0]  sum_reg;
    logic signed [qvr_pkg::VEC_W-1:0]  rot_reg, rot_next;
    logic                              ovf_reg, ovf_next;
    logic signed [qvr_pkg::SUM_W-1:0]  rnd;
    logic signed [qvr_pkg::SH_W-1:0]   sh;

    always_ff @(posedge clk)
    begin
        if (ctl.en1)
        begin
            p0_reg <= row.c0 * vx;
            p1_reg <= row.c1 * vy;
            p2_reg <= row.c2 * vz;
        end
        if (ctl.en2)
            sum_reg <= qvr_pkg::SUM_W'(p0_reg) + qvr_pkg::SUM_W'(p1_reg)
                     + qvr_pkg::SUM_W'(p2_reg);
        if (ctl.en3)
        begin
            rot_reg <= rot_next;
            ovf_reg <= ovf_next;
        end
    end

    always_comb
    begin
        rnd = sum_reg + RND_HALF;
        sh  = rnd[qvr_pkg::SUM_W-1:qvr_pkg::SHIFT];
        if (sh[qvr_pkg::SH_W-1:qvr_pkg::VEC_W-1] == '0
            || sh[qvr_pkg::SH_W-1:qvr_pkg::VEC_W-1] == '1)
        begin
            rot_next = sh[qvr_pkg::VEC_W-1:0];
            ovf_next = 1'b0;
        end
        else
        begin
            rot_next = sh[qvr_pkg::SH_W-1] ? SAT_MIN : SAT_MAX;
            ovf_next = 1'b1;
        end
    end

    assign rot = rot_reg;
    assign ovf = ovf_reg;

endmodule

### hw/rtl/quaternion_vector_rotator_unit.sv
// Top level: quaternion vector rotator, three row lanes and output merge.
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_stall    vec_x, vec_y, vec_z
//  out       source     out_valid / out_stall  rot_x, rot_y, rot_z, overflow
//  cfg       sink       cfg_wr_en              cfg_index, cfg_data
//
// One beat per clock unless stalled; stages are product, sum, round/saturate, merge.
// Each stage holds its beat while the next is full, so bubbles collapse.
// in_stall stays high after reset, and in a register write's own cycle and after it,
// while the matrix pipeline (products, entries) settles.
// out_stall reaches in_stall combinationally through the stage valid chain.
module quaternion_vector_rotator_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [qvr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [qvr_pkg::QUAT_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [qvr_pkg::VEC_W-1:0]    vec_x,
    input  logic signed [qvr_pkg::VEC_W-1:0]    vec_y,
    input  logic signed [qvr_pkg::VEC_W-1:0]    vec_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [qvr_pkg::VEC_W-1:0]    rot_x,
    output logic signed [qvr_pkg::VEC_W-1:0]    rot_y,
    output logic signed [qvr_pkg::VEC_W-1:0]    rot_z,
    output logic                                overflow
);

    qvr_pkg::mat_row_t  row0, row1, row2;
    qvr_pkg::lane_ctl_t ctl;
    logic               busy;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    logic accept;
    logic en4;

    logic signed [qvr_pkg::VEC_W-1:0] lx, ly, lz;
    logic                             ox, oy, oz;

    logic signed [qvr_pkg::VEC_W-1:0] rot_x_reg, rot_y_reg, rot_z_reg;
    logic                             ovf_reg;

    qvr_matrix u_matrix
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .row0      (row0),
        .row1      (row1),
        .row2      (row2),
        .busy      (busy)
    );

    assign rdy4     = !v4_reg || !out_stall;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1 || busy || cfg_wr_en;
    assign accept   = in_valid && !in_stall;

    assign ctl.en1 = accept;
    assign ctl.en2 = v1_reg && rdy2;
    assign ctl.en3 = v2_reg && rdy3;
    assign en4     = v3_reg && rdy4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= accept;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    qvr_lane u_lane_x
    (
        .clk (clk),
        .ctl (ctl),
        .row (row0),
        .vx  (vec_x),
        .vy  (vec_y),
        .vz  (vec_z),
        .rot (lx),
        .ovf (ox)
    );

    qvr_lane u_lane_y
    (
        .clk (clk),
        .ctl (ctl),
        .row (row1),
        .vx  (vec_x),
        .vy  (vec_y),
        .vz  (vec_z),
        .rot (ly),
        .ovf (oy)
    );

    qvr_lane u_lane_z
    (
        .clk (clk),
        .ctl (ctl),
        .row (row2),
        .vx  (vec_x),
        .vy  (vec_y),
        .vz  (vec_z),
        .rot (lz),
        .ovf (oz)
    );

    // merge stage
    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            rot_x_reg <= lx;
            rot_y_reg <= ly;
            rot_z_reg <= lz;
            ovf_reg   <= ox | oy | oz;
        end
    end

    assign out_valid = v4_reg;
    assign rot_x     = rot_x_reg;
    assign rot_y     = rot_y_reg;
    assign rot_z     = rot_z_reg;
    assign overflow  = ovf_reg;

endmodule
